// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 7;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] prio;
  } entry_t;

  // Operation broadcast to every cell; ins and rem are already qualified.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t ent;
  } cell_op_t;

endpackage

// ===== hdl/spq_ifs.sv =====
interface spq_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          req_type;
  logic signed [spq_pkg::DATA_W-1:0]   item_value;
  logic signed [spq_pkg::DATA_W-1:0]   item_priority;

  modport source (output valid, req_type, item_value, item_priority, input ready);
  modport sink   (input valid, req_type, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
  logic                                valid;
  logic                                ready;
  logic                                accepted;
  logic signed [spq_pkg::DATA_W-1:0]   top_value;
  logic [spq_pkg::COUNT_W-1:0]         entry_count;
  logic                                is_full;
  logic                                is_empty;

  modport source (output valid, accepted, top_value, entry_count, is_full, is_empty,
                  input ready);
  modport sink   (input valid, accepted, top_value, entry_count, is_full, is_empty,
                  output ready);
endinterface

// ===== hdl/spq_cell.sv =====
module spq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  spq_pkg::cell_op_t op,
  input  logic [CNT_W-1:0]  count,
  input  logic              prev_disp,
  input  spq_pkg::entry_t   prev_ent,
  input  spq_pkg::entry_t   next_ent,
  output logic              disp,
  output spq_pkg::entry_t   ent_r,
  output spq_pkg::entry_t   ent_nxt
);

  logic occ;

  // Cell zero holds the top entry; an insert displaces every entry of
  // strictly lower priority, so equal priorities keep their arrival order.
  assign occ  = CNT_W'(IDX) < count;
  assign disp = !occ || ($signed(op.ent.prio) > $signed(ent_r.prio));

  always_comb begin
    ent_nxt = ent_r;
    if (op.ins) begin
      if (disp) begin
        ent_nxt = prev_disp ? prev_ent : op.ent;
      end
    end else if (op.rem) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Sorted priority queue built as a chain of entry cells, top entry in cell zero.
// The result of an item is registered and offered in the cycle after acceptance.
// Throughput: one item per cycle while the result register is empty or out_ch.ready is high;
// each item is one broadcast compare and one neighbor shift through the cell chain.
// Reset clears the entry count and the result valid flag; entry contents are not cleared.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  spq_in_if.sink      in_ch,
  spq_out_if.source   out_ch
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                   acc;
  logic                   full;
  logic                   empty;
  logic                   acc_ok;
  spq_pkg::cell_op_t      op;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W+6:0]       cnt_ext;
  logic                   out_valid_r;
  logic                   accepted_r;
  logic [spq_pkg::DATA_W-1:0]  top_r;
  logic [spq_pkg::COUNT_W-1:0] count_out_r;
  logic                   full_r, empty_r;

  logic                   disp     [QUEUE_DEPTH];
  spq_pkg::entry_t        ent_q    [QUEUE_DEPTH];
  spq_pkg::entry_t        ent_nxt  [QUEUE_DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc   = in_ch.valid && in_ch.ready;
  assign full  = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty = count_r == '0;

  always_comb begin
    op.ins       = 1'b0;
    op.rem       = 1'b0;
    op.ent.value = in_ch.item_value;
    op.ent.prio  = in_ch.item_priority;
    acc_ok       = 1'b1;
    count_nxt    = count_r;
    case (in_ch.req_type)
      spq_pkg::REQ_INSERT: begin
        acc_ok = !full;
        op.ins = acc && !full;
        if (op.ins) count_nxt = count_r + 1'b1;
      end
      spq_pkg::REQ_REMOVE: begin
        acc_ok = !empty;
        op.rem = acc && !empty;
        if (op.rem) count_nxt = count_r - 1'b1;
      end
      default: begin
        acc_ok = 1'b1;
      end
    endcase
  end

  assign cnt_ext = {7'd0, count_nxt};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::entry_t pe, ne;
    logic            pd;
    if (i == 0) begin : g_first
      assign pd = 1'b0;
      assign pe = op.ent;
    end else begin : g_mid
      assign pd = disp[i-1];
      assign pe = ent_q[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign ne = ent_q[i];
    end else begin : g_inner
      assign ne = ent_q[i+1];
    end
    spq_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk       (clk),
      .op        (op),
      .count     (count_r),
      .prev_disp (pd),
      .prev_ent  (pe),
      .next_ent  (ne),
      .disp      (disp[i]),
      .ent_r     (ent_q[i]),
      .ent_nxt   (ent_nxt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      accepted_r  <= acc_ok;
      top_r       <= (count_nxt == '0) ? '0 : ent_nxt[0].value;
      count_out_r <= cnt_ext[6:0];
      full_r      <= count_nxt == CNT_W'(QUEUE_DEPTH);
      empty_r     <= count_nxt == '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = accepted_r;
  assign out_ch.top_value   = top_r;
  assign out_ch.entry_count = count_out_r;
  assign out_ch.is_full     = full_r;
  assign out_ch.is_empty    = empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.req_type == spq_pkg::REQ_INSERT && !full)
      |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted insert did not grow the queue");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !acc_ok) |=> count_r == $past(count_r))
    else $error("refused item changed the entry count");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(full_r && empty_r))
    else $error("result reports full and empty at once");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> empty_r == (count_r == '0))
    else $error("result empty flag disagrees with entry count");

endmodule

// ===== dv/tb_sorted_priority_queue.sv =====
module tb_sorted_priority_queue;

  localparam int QUEUE_DEPTH = spq_pkg::DEPTH_DEF;
  localparam int DATA_W = spq_pkg::DATA_W;
  localparam int COUNT_W = spq_pkg::COUNT_W;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_PCT = 27;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic                accepted;
    logic [DATA_W-1:0]   top_value;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_full;
    logic                is_empty;
  } queue_status_t;

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  in_ch();
  spq_out_if out_ch();

  sorted_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Shadow copy of the queue; index model_count - 1 holds the top entry.
  spq_pkg::entry_t model_store [QUEUE_DEPTH];
  int     model_count = 0;

  queue_status_t expected_status[$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  no_gaps = 1'b0;

  function automatic queue_status_t predict_queue_status(input logic [1:0] req,
                                                         input logic [DATA_W-1:0] value,
                                                         input logic [DATA_W-1:0] prio);
    queue_status_t st;
    int pos;
    st.accepted = 1'b1;
    if (req == spq_pkg::REQ_INSERT) begin
      if (model_count >= QUEUE_DEPTH) begin
        st.accepted = 1'b0;
      end else begin
        // Entries with equal priority stay above the new one, so earlier inserts win ties.
        pos = model_count;
        while (pos > 0 && $signed(model_store[pos-1].prio) >= $signed(prio)) begin
          model_store[pos] = model_store[pos-1];
          pos--;
        end
        model_store[pos].value = value;
        model_store[pos].prio  = prio;
        model_count++;
      end
    end else if (req == spq_pkg::REQ_REMOVE) begin
      if (model_count == 0) st.accepted = 1'b0;
      else model_count--;
    end
    st.top_value   = (model_count > 0) ? model_store[model_count-1].value : '0;
    st.entry_count = COUNT_W'(model_count);
    st.is_full     = (model_count == QUEUE_DEPTH);
    st.is_empty    = (model_count == 0);
    return st;
  endfunction

  task automatic send_request(input logic [1:0] req, input logic [DATA_W-1:0] value,
                              input logic [DATA_W-1:0] prio);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= req;
    in_ch.item_value    <= value;
    in_ch.item_priority <= prio;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_status.push_back(predict_queue_status(req, value, prio));
  endtask

  function automatic logic [DATA_W-1:0] pick_priority();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return DATA_W'($urandom_range(8) - 4);
    if (roll < 50) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  task automatic run_random_requests(input int n);
    bit filling;
    int roll;
    logic [1:0] req;
    filling = (model_count < QUEUE_DEPTH / 2);
    repeat (n) begin
      // Swing the fill level between empty and full so both refusals get hit.
      if (model_count == QUEUE_DEPTH && $urandom_range(99) < 80) filling = 1'b0;
      if (model_count == 0 && $urandom_range(99) < 80) filling = 1'b1;
      if ($urandom_range(99) < 2) filling = !filling;
      roll = $urandom_range(99);
      if (roll < 10) req = $urandom_range(1) ? spq_pkg::REQ_QUERY : REQ_UNUSED;
      else if (roll < 70) req = filling ? spq_pkg::REQ_INSERT : spq_pkg::REQ_REMOVE;
      else req = filling ? spq_pkg::REQ_REMOVE : spq_pkg::REQ_INSERT;
      send_request(req, $urandom, pick_priority());
    end
  endtask

  task automatic test_directed_cases();
    send_request(spq_pkg::REQ_QUERY,  32'h0, 32'h0);
    send_request(spq_pkg::REQ_REMOVE, 32'hDEAD_BEEF, 32'h1234_5678);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(spq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(spq_pkg::REQ_INSERT, 32'h8000_0000, 32'h8000_0000);
    send_request(spq_pkg::REQ_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_request(spq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Three entries at one priority must come out in insertion order.
    send_request(spq_pkg::REQ_INSERT, 32'h0000_00A1, 32'h0000_0005);
    send_request(spq_pkg::REQ_INSERT, 32'h0000_00B2, 32'h0000_0005);
    send_request(spq_pkg::REQ_INSERT, 32'h0000_00C3, 32'h0000_0005);
    send_request(spq_pkg::REQ_QUERY,  32'h5555_5555, 32'hAAAA_AAAA);
    send_request(spq_pkg::REQ_REMOVE, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(spq_pkg::REQ_REMOVE, 32'h0, 32'h0);
    send_request(REQ_UNUSED, 32'h1234_5678, 32'h8765_4321);
    repeat (6) send_request(spq_pkg::REQ_REMOVE, $urandom, $urandom);
    send_request(spq_pkg::REQ_QUERY, 32'h0, 32'h0);
  endtask

  task automatic test_fill_and_drain();
    repeat (QUEUE_DEPTH)
      send_request(spq_pkg::REQ_INSERT, $urandom, DATA_W'($urandom_range(6) - 3));
    repeat (2) send_request(spq_pkg::REQ_INSERT, $urandom, 32'h7FFF_FFFF);
    send_request(spq_pkg::REQ_QUERY, $urandom, $urandom);
    repeat (QUEUE_DEPTH) send_request(spq_pkg::REQ_REMOVE, $urandom, $urandom);
    repeat (2) send_request(spq_pkg::REQ_REMOVE, $urandom, $urandom);
  endtask

  task automatic test_random_back_to_back();
    no_gaps = 1'b1;
    run_random_requests(350);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_with_gaps();
    run_random_requests(1000);
  endtask

  always @(posedge clk) begin
    out_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    queue_status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_status.size() == 0) begin
        $error("result item arrived with no request outstanding");
        error_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("accepted", DATA_W'(want.accepted), DATA_W'(out_ch.accepted));
        check_field("top_value", want.top_value, out_ch.top_value);
        check_field("entry_count", DATA_W'(want.entry_count),
                    DATA_W'(out_ch.entry_count));
        check_field("is_full", DATA_W'(want.is_full), DATA_W'(out_ch.is_full));
        check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(out_ch.is_empty));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_priority_queue: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= spq_pkg::REQ_QUERY;
    in_ch.item_value    <= '0;
    in_ch.item_priority <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_fill_and_drain();
    test_random_back_to_back();
    test_random_with_gaps();

    in_ch.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("sorted_priority_queue: match");
    end else begin
      $display("sorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/spq_pkg.sv
hdl/spq_ifs.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
dv/tb_sorted_priority_queue.sv
